[rtl/afb_pkg.sv]
// ----------------------------------------------------------------------------
// afb_pkg: shared types and constants of the ARQ frame builder
// Request payloads, the queued command format and the CRC-16 byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package afb_pkg;

  localparam int unsigned SizeW = 11;
  localparam logic [SizeW-1:0] MaxPayload = SizeW'(1232);
  localparam int unsigned HdrBytes = 9;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // header byte positions
  localparam logic [3:0] PhFlag  = 4'd0;
  localparam logic [3:0] PhSeq3  = 4'd1;
  localparam logic [3:0] PhSeq2  = 4'd2;
  localparam logic [3:0] PhSeq1  = 4'd3;
  localparam logic [3:0] PhSeq0  = 4'd4;
  localparam logic [3:0] PhSize3 = 4'd5;
  localparam logic [3:0] PhSize2 = 4'd6;
  localparam logic [3:0] PhSize1 = 4'd7;
  localparam logic [3:0] PhSize0 = 4'd8;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             byte_valid;
    logic [31:0]      seq_number;
    logic [SizeW-1:0] payload_size;
    logic             end_flag;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_t;

  // one classified request: optional header, optional data byte, optional checksum
  typedef struct packed {
    logic             is_header;
    logic             flag;
    logic [31:0]      seq;
    logic [SizeW-1:0] size;
    logic             has_data;
    logic [7:0]       data;
    logic             close;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/afb_front.sv]
// ----------------------------------------------------------------------------
// afb_front: request classifier
// Tracks frame position and turns each accepted request into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module afb_front
  import afb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  input  wire logic q_full_i,
  output logic      q_push_o,
  output cmd_t      q_cmd_o
);

  logic             inside_q, inside_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [SizeW-1:0] size_sat, size_eff;
  logic             fire;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  assign size_sat = (in_data_i.payload_size > MaxPayload) ? MaxPayload
                                                          : in_data_i.payload_size;
  assign size_eff = in_data_i.byte_valid ? size_sat : '0;

  always_comb begin
    inside_d  = inside_q;
    rem_d     = rem_q;
    q_push_o  = 1'b0;
    q_cmd_o.is_header = 1'b0;
    q_cmd_o.flag      = !in_data_i.end_flag;
    q_cmd_o.seq       = in_data_i.seq_number;
    q_cmd_o.size      = size_eff;
    q_cmd_o.has_data  = 1'b0;
    q_cmd_o.data      = in_data_i.data_byte;
    q_cmd_o.close     = 1'b0;
    if (!inside_q) begin
      q_cmd_o.is_header = 1'b1;
      q_cmd_o.has_data  = (size_eff != '0);
      q_cmd_o.close     = (size_eff <= SizeW'(1));
      if (fire) begin
        q_push_o = 1'b1;
        inside_d = (size_eff > SizeW'(1));
        rem_d    = size_eff - SizeW'(1);
      end
    end else begin
      q_cmd_o.has_data = 1'b1;
      q_cmd_o.close    = (rem_q == SizeW'(1));
      // an idle request inside a frame is taken and dropped
      if (fire && in_data_i.byte_valid) begin
        q_push_o = 1'b1;
        rem_d    = rem_q - SizeW'(1);
        inside_d = (rem_q != SizeW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      rem_q    <= '0;
    end else begin
      inside_q <= inside_d;
      rem_q    <= rem_d;
    end
  end

endmodule

`default_nettype wire

[rtl/afb_queue.sv]
// ----------------------------------------------------------------------------
// afb_queue: two-entry command queue
// Decouples the classifier from the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module afb_queue
  import afb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

[rtl/afb_back.sv]
// ----------------------------------------------------------------------------
// afb_back: byte sequencer
// Expands each command into header, data and checksum bytes, runs the CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module afb_back
  import afb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire cmd_t q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic [3:0]  ph_q;
  logic [15:0] crc_q;
  logic        out_valid_q;
  out_t        out_q;

  logic [3:0]  hdr_len, total;
  logic        step, last, in_hdr, is_data;
  logic [7:0]  hdr_byte, byte_sel;
  logic [31:0] size32;
  logic [15:0] crc_base;

  assign size32  = {{(32-SizeW){1'b0}}, q_cmd_i.size};
  assign hdr_len = q_cmd_i.is_header ? 4'(HdrBytes) : 4'd0;
  assign total   = hdr_len + 4'(q_cmd_i.has_data) + 4'(q_cmd_i.close);
  assign in_hdr  = (ph_q < hdr_len);
  assign is_data = !in_hdr && q_cmd_i.has_data && (ph_q == hdr_len);
  assign last    = (ph_q == total - 4'd1);
  assign step    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = step && last;

  always_comb begin
    case (ph_q)
      PhFlag:  hdr_byte = {7'd0, q_cmd_i.flag};
      PhSeq3:  hdr_byte = q_cmd_i.seq[31:24];
      PhSeq2:  hdr_byte = q_cmd_i.seq[23:16];
      PhSeq1:  hdr_byte = q_cmd_i.seq[15:8];
      PhSeq0:  hdr_byte = q_cmd_i.seq[7:0];
      PhSize3: hdr_byte = size32[31:24];
      PhSize2: hdr_byte = size32[23:16];
      PhSize1: hdr_byte = size32[15:8];
      PhSize0: hdr_byte = size32[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (in_hdr) begin
      byte_sel = hdr_byte;
    end else if (is_data) begin
      byte_sel = q_cmd_i.data;
    end else begin
      byte_sel = crc_q[7:0];
    end
  end

  // header restarts the CRC
  assign crc_base = (q_cmd_i.is_header && ph_q == PhFlag) ? CrcInit : crc_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.frame_byte <= byte_sel;
      out_q.frame_last <= !in_hdr && !is_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= 4'd0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
        ph_q        <= last ? 4'd0 : ph_q + 4'd1;
        if (in_hdr || is_data) begin
          crc_q <= crc_byte(crc_base, byte_sel);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/arq_frame_builder_crc16.sv]
// ----------------------------------------------------------------------------
// arq_frame_builder_crc16: ARQ data frame serializer with CRC-16
// Emits header, payload and a one-byte checksum per frame.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------
//  in      | in_valid_i/in_ready_o   | in_data_i (afb_pkg::in_t)
//  out     | out_valid_o/out_ready_i | out_data_o (afb_pkg::out_t)
//
//  One output byte per cycle while a command is queued and out_ready_i allows.
//  A payload request yields one byte, two when it closes the frame; the first
//  request of a frame yields 9 header bytes plus data and checksum bytes.
//  The byte sequencer is the rate limit; a 2-entry queue sits in front of it.
//  Reset clears frame position, queue and output valid; CRC restarts at header.
//  Output stalls back up through the queue into in_ready_o.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_frame_builder_crc16
  import afb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  afb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  afb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (head_cmd)
  );

  afb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
